>>> rtl/core/a2i_pkg.sv
package a2i_pkg;

    localparam int WORD_BITS  = 32;
    localparam int RADIX_W    = 6;
    localparam int CHAR_W     = 8;
    localparam int PROD_W     = WORD_BITS + RADIX_W;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 40;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = RADIX_W;

    localparam logic [CFG_ADDR_W-1:0] REG_RADIX       = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SIGNED_MODE = 1'd1;

    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_X = 8'h78;
    localparam logic [CHAR_W-1:0] CASE_BIT   = 8'h20;
    localparam logic [CHAR_W-1:0] DIGIT_NONE = 8'd40;
    localparam logic [CHAR_W-1:0] ALPHA_BIAS = 8'd87;

    localparam logic [RADIX_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [RADIX_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [RADIX_W-1:0] BASE_HEX  = 6'd16;
    localparam logic [RADIX_W-1:0] BASE_MIN  = 6'd2;
    localparam logic [RADIX_W-1:0] BASE_MAX  = 6'd36;
    localparam logic [RADIX_W-1:0] AUTO_MASK = 6'h2F;

    localparam logic [WORD_BITS-1:0] WORD_ONES = {WORD_BITS{1'b1}};
    localparam logic [WORD_BITS-1:0] NEG_LIMIT = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic [WORD_BITS-1:0] POS_LIMIT = {1'b0, {(WORD_BITS-1){1'b1}}};

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_PREFIX,
        PH_AFTER0,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    typedef struct packed {
        phase_t                phase;
        logic                  is_negative;
        logic [RADIX_W-1:0]    active_base;
        logic [WORD_BITS-1:0]  accumulator;
        logic                  overflowed;
    } parse_state_t;

    localparam parse_state_t STATE_CLEAR = '{
        phase:       PH_SPACE,
        is_negative: 1'b0,
        active_base: '0,
        accumulator: '0,
        overflowed:  1'b0
    };

    function automatic logic [CHAR_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] num;
        logic [CHAR_W-1:0] low;
        num = c - CH_ZERO;
        low = c | CASE_BIT;
        if (num <= 8'd9) begin
            digit_of = num;
        end else if (low >= CH_LOWER_A) begin
            digit_of = low - ALPHA_BIAS;
        end else begin
            digit_of = DIGIT_NONE;
        end
    endfunction

endpackage

>>> rtl/core/a2i_step.sv
module a2i_step (
    input  a2i_pkg::parse_state_t         state_in,
    input  logic [a2i_pkg::CHAR_W-1:0]    char_code,
    input  logic [a2i_pkg::RADIX_W-1:0]   radix,
    input  logic                          signed_mode,
    output a2i_pkg::parse_state_t         state_out
);

    logic                            taken;
    logic                            base_ok;
    logic [a2i_pkg::CHAR_W-1:0]      digit;
    logic [a2i_pkg::RADIX_W-1:0]     base_dec;
    logic [a2i_pkg::PROD_W-1:0]      product;

    assign digit = a2i_pkg::digit_of(char_code);

    always_comb begin
        state_out = state_in;
        taken     = 1'b0;
        base_ok   = 1'b0;
        base_dec  = '0;
        product   = '0;

        if (state_out.phase == a2i_pkg::PH_SPACE) begin
            if (char_code == a2i_pkg::CH_SPACE || char_code == a2i_pkg::CH_TAB ||
                char_code == a2i_pkg::CH_CR || char_code == a2i_pkg::CH_LF) begin
                taken = 1'b1;
            end else begin
                state_out.phase = a2i_pkg::PH_PREFIX;
                if (char_code == a2i_pkg::CH_MINUS || char_code == a2i_pkg::CH_PLUS) begin
                    state_out.is_negative = (char_code == a2i_pkg::CH_MINUS);
                    taken = 1'b1;
                end
            end
        end

        if (!taken && state_out.phase == a2i_pkg::PH_PREFIX) begin
            if ((radix & a2i_pkg::AUTO_MASK) == '0) begin
                if (char_code == a2i_pkg::CH_ZERO) begin
                    state_out.active_base = radix + a2i_pkg::BASE_OCT;
                    state_out.phase       = a2i_pkg::PH_AFTER0;
                    taken                 = 1'b1;
                end else begin
                    base_dec = radix + a2i_pkg::BASE_DEC;
                    state_out.active_base = (base_dec > a2i_pkg::BASE_HEX) ?
                                            a2i_pkg::BASE_HEX : base_dec;
                    state_out.phase       = a2i_pkg::PH_DIGITS;
                end
            end else begin
                state_out.active_base = radix;
                state_out.phase       = a2i_pkg::PH_DIGITS;
            end
        end

        if (!taken && state_out.phase == a2i_pkg::PH_AFTER0) begin
            if ((char_code | a2i_pkg::CASE_BIT) == a2i_pkg::CH_LOWER_X) begin
                state_out.active_base = state_out.active_base + state_out.active_base;
                taken = 1'b1;
            end
            if (state_out.active_base > a2i_pkg::BASE_HEX) begin
                state_out.active_base = a2i_pkg::BASE_HEX;
            end
            state_out.phase = a2i_pkg::PH_DIGITS;
        end

        if (!taken && state_out.phase == a2i_pkg::PH_DIGITS) begin
            base_ok = (state_out.active_base >= a2i_pkg::BASE_MIN) &&
                      (state_out.active_base <= a2i_pkg::BASE_MAX);
            if (!base_ok) begin
                state_out.accumulator = '0;
                state_out.phase       = a2i_pkg::PH_DONE;
            end else if (digit >= {2'b00, state_out.active_base}) begin
                state_out.phase = a2i_pkg::PH_DONE;
            end else begin
                // acc * base + d exceeds the word exactly when strtoul would overflow
                product = {{a2i_pkg::RADIX_W{1'b0}}, state_out.accumulator} *
                          {{a2i_pkg::WORD_BITS{1'b0}}, state_out.active_base} +
                          {{(a2i_pkg::PROD_W-a2i_pkg::CHAR_W){1'b0}}, digit};
                if (product > {{a2i_pkg::RADIX_W{1'b0}}, a2i_pkg::WORD_ONES}) begin
                    state_out.accumulator = a2i_pkg::WORD_ONES;
                    state_out.is_negative = state_out.is_negative & signed_mode;
                    state_out.overflowed  = 1'b1;
                end else begin
                    state_out.accumulator = product[a2i_pkg::WORD_BITS-1:0];
                end
            end
        end
    end

endmodule

>>> rtl/core/ascii_to_integer_parser.sv
// ASCII to integer converter (strtol/strtoul style). One character is taken per
// transfer on s_ and the block sustains one character per clock. A character sits
// in the input register while a combinational parse step (digit decode plus a 32x6
// multiply-accumulate with overflow compare) updates the running state; the result
// of the string is registered and appears on m_ once the character flagged by s_tlast
// leaves the input register, and one result is produced per string. s_tready drops
// only while a string's last character waits behind a result that m_ has not taken.
// Leading blanks and an optional sign are skipped, radix 0 auto-detects 8/10/16 from
// a 0 or 0x prefix, and overflow saturates or clamps with range_error set. Write radix
// and signed_mode via the cfg_ port only while no string is in flight.
module ascii_to_integer_parser (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [a2i_pkg::S_TDATA_W-1:0]     s_tdata,   // [7:0] char_code
    input  logic                              s_tlast,   // last_char
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [a2i_pkg::M_TDATA_W-1:0]     m_tdata,   // [31:0] value, [32] range_error, rest 0
    input  logic                              cfg_we,
    input  logic [a2i_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [a2i_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    logic [a2i_pkg::RADIX_W-1:0]   radix_reg;
    logic                          signed_mode_reg;

    logic                          in_valid_reg;
    logic [a2i_pkg::CHAR_W-1:0]    in_char_reg;
    logic                          in_last_reg;

    a2i_pkg::parse_state_t         state_reg;
    a2i_pkg::parse_state_t         state_next;
    a2i_pkg::parse_state_t         step_state;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [a2i_pkg::WORD_BITS-1:0] out_value_reg;
    logic [a2i_pkg::WORD_BITS-1:0] out_value_next;
    logic                          out_err_reg;
    logic                          out_err_next;

    logic                          advance;
    logic [a2i_pkg::WORD_BITS-1:0] limit;

    a2i_step u_step (
        .state_in    (state_reg),
        .char_code   (in_char_reg),
        .radix       (radix_reg),
        .signed_mode (signed_mode_reg),
        .state_out   (step_state)
    );

    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        state_next = state_reg;
        if (advance) begin
            state_next = in_last_reg ? a2i_pkg::STATE_CLEAR : step_state;
        end
    end

    always_comb begin
        limit          = step_state.is_negative ? a2i_pkg::NEG_LIMIT : a2i_pkg::POS_LIMIT;
        out_value_next = step_state.accumulator;
        out_err_next   = step_state.overflowed;
        if (signed_mode_reg && step_state.accumulator > limit) begin
            out_value_next = limit;
            out_err_next   = 1'b1;
        end
        if (step_state.is_negative) begin
            out_value_next = '0 - out_value_next;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance && in_last_reg) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radix_reg       <= '0;
            signed_mode_reg <= 1'b1;
        end else if (cfg_we) begin
            case (cfg_addr)
                a2i_pkg::REG_RADIX:       radix_reg       <= cfg_wdata;
                a2i_pkg::REG_SIGNED_MODE: signed_mode_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            state_reg     <= a2i_pkg::STATE_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg <= s_tdata[a2i_pkg::CHAR_W-1:0];
            in_last_reg <= s_tlast;
        end
        if (advance && in_last_reg) begin
            out_value_reg <= out_value_next;
            out_err_reg   <= out_err_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(a2i_pkg::M_TDATA_W-a2i_pkg::WORD_BITS-1){1'b0}},
                       out_err_reg, out_value_reg};

endmodule

>>> rtl/core/a2i_checker.sv
module a2i_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [a2i_pkg::M_TDATA_W-1:0]     m_tdata
);

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a blocked result");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[a2i_pkg::WORD_BITS] |->
            m_tdata[a2i_pkg::WORD_BITS-1:0] == a2i_pkg::WORD_ONES ||
            m_tdata[a2i_pkg::WORD_BITS-1:0] == a2i_pkg::POS_LIMIT ||
            m_tdata[a2i_pkg::WORD_BITS-1:0] == a2i_pkg::NEG_LIMIT)
        else $error("range error with a non-saturated value");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[a2i_pkg::M_TDATA_W-1:a2i_pkg::WORD_BITS+1] == '0)
        else $error("result padding bits not zero");

endmodule

bind ascii_to_integer_parser a2i_checker u_a2i_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
